// ===== hw/rtl/a2bc_pkg.sv =====
package a2bc_pkg;

    localparam int BLOCK_WORDS = 128;
    localparam int PAIRS       = BLOCK_WORDS / 2;
    localparam int ADDR_W      = $clog2(BLOCK_WORDS);
    localparam int PAIR_W      = $clog2(PAIRS);

    typedef struct packed {
        logic [63:0] x_even;
        logic [63:0] x_odd;
        logic [63:0] y_even;
        logic [63:0] y_odd;
        logic [63:0] old_even;
        logic [63:0] old_odd;
        logic        accumulate;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] out_even;
        logic [63:0] out_odd;
        logic        block_end;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MIX,
        ST_WRITE,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_we;
        logic                rd_en;
        logic [3:0]          rd_idx;
        logic [2:0]          grp;
        logic                col_pass;
        logic                mix_start;
        logic                wr_en;
        logic [3:0]          wr_idx;
        logic                emit_rd;
        logic [PAIR_W-1:0]   emit_pair;
        logic                out_load;
        logic                out_last;
    } a2bc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mix_done;
    } a2bc_sts_t;

    function automatic logic [63:0] blamka(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] p);
        blamka = a + b + {p[62:0], 1'b0};
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input logic [5:0] n);
        rotr = (x >> n) | (x << (7'd64 - {1'b0, n}));
    endfunction

endpackage

// ===== hw/rtl/a2bc_ram.sv =====
module a2bc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/a2bc_ctrl.sv =====
module a2bc_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    output a2bc_pkg::a2bc_cmd_t             cmd,
    input  a2bc_pkg::a2bc_sts_t             sts
);
    import a2bc_pkg::*;

    state_t            state_reg, state_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [4:0]        idx_reg, idx_next;
    logic [3:0]        grp_reg, grp_next;   // 0..7 rows, 8..15 columns
    logic [3:0]        rnd_reg, rnd_next;   // mix step within round, 0..7
    logic              emit_pend_reg, emit_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            pair_reg      <= '0;
            idx_reg       <= '0;
            grp_reg       <= '0;
            rnd_reg       <= '0;
            emit_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pair_reg      <= pair_next;
            idx_reg       <= idx_next;
            grp_reg       <= grp_next;
            rnd_reg       <= rnd_next;
            emit_pend_reg <= emit_pend_next;
        end
    end

    logic out_free;
    assign out_free = !m_valid || m_ready;

    // next state
    always_comb begin
        state_next     = state_reg;
        pair_next      = pair_reg;
        idx_next       = idx_reg;
        grp_next       = grp_reg;
        rnd_next       = rnd_reg;
        emit_pend_next = emit_pend_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    pair_next = pair_reg + 1'b1;
                    if (pair_reg == PAIR_W'(PAIRS - 1)) begin
                        state_next = ST_READ;
                        idx_next   = '0;
                        grp_next   = '0;
                    end
                end
            end
            ST_READ: begin
                // the extra pass at idx 16 drains the last read
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 5'd16) begin
                    state_next = ST_MIX;
                    rnd_next   = '0;
                end
            end
            ST_MIX: begin
                if (sts.mix_done) begin
                    rnd_next = rnd_reg + 1'b1;
                    if (rnd_reg == 4'd7) begin
                        state_next = ST_WRITE;
                        idx_next   = '0;
                    end
                end
            end
            ST_WRITE: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 5'd15) begin
                    idx_next = '0;
                    grp_next = grp_reg + 1'b1;
                    if (grp_reg == 4'd15) begin
                        state_next     = ST_EMIT;
                        emit_pend_next = 1'b0;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                // read issued this cycle, loaded into output once the output register is free
                if (out_free || !emit_pend_reg) begin
                    emit_pend_next = 1'b1;
                    if (emit_pend_reg) begin
                        pair_next = pair_reg + 1'b1;
                    end
                    if (emit_pend_reg && pair_reg == PAIR_W'(PAIRS - 1)) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                    pair_next  = '0;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    logic [PAIR_W-1:0] emit_addr;
    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        // while stalled, keep re-reading the pending pair so the read data holds
        emit_addr = (emit_pend_reg && out_free) ? pair_reg + 1'b1 : pair_reg;
        cmd.grp      = grp_reg[2:0];
        cmd.col_pass = grp_reg[3];
        cmd.rd_idx   = idx_reg[3:0];
        cmd.wr_idx   = idx_reg[3:0];
        cmd.emit_pair = emit_addr;
        cmd.out_last = (pair_reg == PAIR_W'(PAIRS - 1));
        unique case (state_reg)
            ST_LOAD: begin
                s_ready      = 1'b1;
                cmd.load_we  = s_valid;
                cmd.emit_pair = pair_reg;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_MIX: begin
                cmd.mix_start = 1'b1;
                cmd.rd_idx    = rnd_reg;
            end
            ST_WRITE: begin
                cmd.wr_en = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit_rd  = 1'b1;
                cmd.out_load = emit_pend_reg && out_free;
            end
            ST_DRAIN: begin
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== hw/rtl/a2bc_dpath.sv =====
module a2bc_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  a2bc_pkg::in_beat_t    s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output a2bc_pkg::out_beat_t   m_data,
    input  a2bc_pkg::a2bc_cmd_t   cmd,
    output a2bc_pkg::a2bc_sts_t   sts
);
    import a2bc_pkg::*;

    // Work and fold blocks each as even/odd RAM pairs, one word pair per address.
    logic              we_w;
    logic [PAIR_W-1:0] waddr_w, raddr_w, raddr_f;
    logic [63:0]       wd_we, wd_wo, rd_we, rd_wo, rd_fe, rd_fo;
    logic [63:0]       fe, fo, re, ro;

    assign re = s_data.x_even ^ s_data.y_even;
    assign ro = s_data.x_odd  ^ s_data.y_odd;
    assign fe = s_data.accumulate ? re ^ s_data.old_even : re;
    assign fo = s_data.accumulate ? ro ^ s_data.old_odd  : ro;

    // Pair index of local pair j (0..7) in the current row or column.
    function automatic logic [PAIR_W-1:0] grp_addr(input logic col, input logic [2:0] g,
                                                    input logic [2:0] j);
        grp_addr = col ? {j, g} : {g, j};
    endfunction

    // Local word buffer, 16 words
    logic [63:0] v_reg [16];
    logic [63:0] v_next [16];

    logic [3:0] rd_idx_d_reg;
    logic       rd_en_d_reg;

    assign we_w    = cmd.load_we || (cmd.wr_en && !cmd.wr_idx[0]);
    assign waddr_w = cmd.load_we ? cmd.emit_pair
                                 : grp_addr(cmd.col_pass, cmd.grp, cmd.wr_idx[3:1]);
    assign wd_we   = cmd.load_we ? re : v_reg[{cmd.wr_idx[3:1], 1'b0}];
    assign wd_wo   = cmd.load_we ? ro : v_reg[{cmd.wr_idx[3:1], 1'b1}];
    assign raddr_w = cmd.emit_rd ? cmd.emit_pair
                                 : grp_addr(cmd.col_pass, cmd.grp, cmd.rd_idx[3:1]);
    assign raddr_f = cmd.emit_pair;

    a2bc_ram #(.WIDTH(64), .DEPTH(PAIRS)) u_work_e (.aclk(aclk), .we(we_w), .waddr(waddr_w),
        .wdata(wd_we), .raddr(raddr_w), .rdata(rd_we));
    a2bc_ram #(.WIDTH(64), .DEPTH(PAIRS)) u_work_o (.aclk(aclk), .we(we_w), .waddr(waddr_w),
        .wdata(wd_wo), .raddr(raddr_w), .rdata(rd_wo));
    a2bc_ram #(.WIDTH(64), .DEPTH(PAIRS)) u_fold_e (.aclk(aclk), .we(cmd.load_we),
        .waddr(cmd.emit_pair), .wdata(fe), .raddr(raddr_f), .rdata(rd_fe));
    a2bc_ram #(.WIDTH(64), .DEPTH(PAIRS)) u_fold_o (.aclk(aclk), .we(cmd.load_we),
        .waddr(cmd.emit_pair), .wdata(fo), .raddr(raddr_f), .rdata(rd_fo));

    // Mixing unit: one G at a time, one multiplier, registered between steps.
    logic [3:0]  ph_reg, ph_next;
    logic [63:0] a_reg, b_reg, c_reg, d_reg, p_reg;
    logic [63:0] a_next, b_next, c_next, d_next, p_next;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    always_comb begin
        ia = {2'b00, cmd.rd_idx[1:0]};
        if (!cmd.rd_idx[2]) begin
            ib = 4'd4  + {2'b00, cmd.rd_idx[1:0]};
            ic = 4'd8  + {2'b00, cmd.rd_idx[1:0]};
            id = 4'd12 + {2'b00, cmd.rd_idx[1:0]};
        end else begin
            ib = 4'd4  + {2'b00, 2'(cmd.rd_idx[1:0] + 2'd1)};
            ic = 4'd8  + {2'b00, 2'(cmd.rd_idx[1:0] + 2'd2)};
            id = 4'd12 + {2'b00, 2'(cmd.rd_idx[1:0] + 2'd3)};
        end
    end

    // Shared multiplier operands: a*b on load and in phase 4, c*d in phases 2 and 6.
    always_comb begin
        unique case (ph_reg)
            4'd0: begin
                mul_a = v_reg[ia][31:0];
                mul_b = v_reg[ib][31:0];
            end
            4'd4: begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[31:0];
            end
            default: begin
                mul_a = c_reg[31:0];
                mul_b = d_reg[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    logic [63:0] bl;
    assign bl = blamka(ph_reg[1] ? c_reg : a_reg, ph_reg[1] ? d_reg : b_reg, p_reg);

    always_comb begin
        ph_next = ph_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; p_next = p_reg;
        for (int i = 0; i < 16; i++) begin
            v_next[i] = v_reg[i];
        end
        sts.mix_done = 1'b0;
        if (rd_en_d_reg) begin
            v_next[{rd_idx_d_reg[3:1], 1'b0}] = rd_we;
            v_next[{rd_idx_d_reg[3:1], 1'b1}] = rd_wo;
        end
        if (cmd.mix_start) begin
            // phases 0, 2, 4 and 6 multiply, odd phases add and rotate, phase 8 writes back
            unique case (ph_reg)
                4'd0: begin
                    a_next = v_reg[ia]; b_next = v_reg[ib];
                    c_next = v_reg[ic]; d_next = v_reg[id];
                    p_next = prod;
                    ph_next = 4'd1;
                end
                4'd1, 4'd5: begin
                    a_next = bl;
                    d_next = rotr(d_reg ^ bl, (ph_reg == 4'd1) ? 6'd32 : 6'd16);
                    ph_next = ph_reg + 4'd1;
                end
                4'd2, 4'd6: begin
                    p_next = prod;
                    ph_next = ph_reg + 4'd1;
                end
                4'd3, 4'd7: begin
                    c_next = bl;
                    b_next = rotr(b_reg ^ bl, (ph_reg == 4'd3) ? 6'd24 : 6'd63);
                    ph_next = ph_reg + 4'd1;
                end
                4'd4: begin
                    p_next = prod;
                    ph_next = 4'd5;
                end
                4'd8: begin
                    v_next[ia] = a_reg; v_next[ib] = b_reg;
                    v_next[ic] = c_reg; v_next[id] = d_reg;
                    sts.mix_done = 1'b1;
                    ph_next = 4'd0;
                end
                default: ph_next = 4'd0;
            endcase
        end
    end

    out_beat_t obuf_reg;
    logic      ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= '0;
            rd_en_d_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            rd_en_d_reg <= cmd.rd_en;
            ovalid_reg  <= ovalid_next;
        end
        rd_idx_d_reg <= cmd.rd_idx;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next; p_reg <= p_next;
        for (int i = 0; i < 16; i++) begin
            v_reg[i] <= v_next[i];
        end
        if (cmd.out_load) begin
            obuf_reg.out_even  <= rd_we ^ rd_fe;
            obuf_reg.out_odd   <= rd_wo ^ rd_fo;
            obuf_reg.block_end <= cmd.out_last;
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        if (m_ready) begin
            ovalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            ovalid_next = 1'b1;
        end
    end

    assign m_valid = ovalid_reg;
    assign m_data  = obuf_reg;
endmodule

// ===== hw/rtl/argon2_block_compression.sv =====
// Argon2 compression G (BlaMka) on one 1024-byte block.
// Input channel s_*: one beat carries a word pair of X, Y and the old block
// plus the accumulate flag; 64 beats make a block, taken one per cycle.
// After the 64th beat the block runs eight row rounds and eight column
// rounds of eight mixing steps each on one shared mixing unit (one 32x32
// multiplier), each round framed by a read and a write of its 16 words
// through the work memory port. After the permutation, the first result
// follows one memory read and one output register load.
// Result channel m_*: 64 beats of out_even/out_odd, block_end on the last,
// one per cycle while the receiver keeps up; input reopens the cycle after
// the last beat is taken.
// Results go through a single output register; while the receiver stalls
// the emitter holds and nothing is lost. No input is taken during
// permutation or emission. Reset (aresetn low, synchronous) returns the
// controller to loading pair 0 and drops any pending result; the memories
// keep stale data, which is always overwritten before it is read.
module argon2_block_compression #(
    parameter int BLOCK_WORDS = a2bc_pkg::BLOCK_WORDS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  a2bc_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output a2bc_pkg::out_beat_t  m_data
);
    import a2bc_pkg::*;

    a2bc_cmd_t cmd;
    a2bc_sts_t sts;

    // Datapath fixes a 128-word block.
    logic unused_ok;
    assign unused_ok = (BLOCK_WORDS == a2bc_pkg::BLOCK_WORDS);

    a2bc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid && unused_ok),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    a2bc_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );
endmodule

// ===== hw/rtl/a2bc_checker.sv =====
module a2bc_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input a2bc_pkg::out_beat_t m_data
);
    import a2bc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while results pending");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.block_end |=> !m_valid)
        else $error("beat after block end");
endmodule

bind argon2_block_compression a2bc_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
